[design/clcd_pkg.sv]
// Shared types, register indexes and the pin-state step table of the LCD
// write sequencer. Used by the controller, the datapath and the interfaces.
package clcd_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 20;
  localparam int HoldWidth     = 20;
  localparam int StepWidth     = 5;

  // Operation codes carried by a request.
  localparam logic [2:0] OP_DATA    = 3'd0;
  localparam logic [2:0] OP_COMMAND = 3'd1;
  localparam logic [2:0] OP_INIT    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_CURSOR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_DATA_WAIT    = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_COMMAND_WAIT = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_STROBE       = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_POWER_WAIT   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_INIT_STEP    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_DISPLAY_ON   = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_CLEAR_CODE   = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [15:0] DataWaitReset    = 16'd500;
  localparam logic [15:0] CommandWaitReset = 16'd1000;
  localparam logic [7:0]  StrobeReset      = 8'd10;
  localparam logic [19:0] PowerWaitReset   = 20'd100000;
  localparam logic [15:0] InitStepReset    = 16'd10000;
  localparam logic [7:0]  DisplayOnReset   = 8'h0C;
  localparam logic [7:0]  ClearCodeReset   = 8'h01;

  typedef enum logic [1:0] {RS_HELD, RS_COMMAND, RS_DATA} rs_sel_t;
  typedef enum logic [2:0] {NIB_HELD, NIB_HIGH, NIB_LOW, NIB_WAKE, NIB_FOUR_BIT} nib_sel_t;
  typedef enum logic [2:0] {
    HOLD_STROBE, HOLD_ZERO, HOLD_DATA, HOLD_COMMAND, HOLD_POWER, HOLD_INIT_STEP
  } hold_sel_t;
  typedef enum logic [1:0] {BYTE_VALUE, BYTE_DISPLAY_ON, BYTE_CLEAR, BYTE_CURSOR} byte_sel_t;

  // One pin state, described by where each of its fields comes from.
  typedef struct packed {
    rs_sel_t   rs_sel;
    logic      enable;
    nib_sel_t  nib_sel;
    hold_sel_t hold_sel;
    byte_sel_t byte_sel;
    logic      last;
  } step_desc_t;

  typedef struct packed {
    logic       load_item;
    logic       load_out;
    step_desc_t desc;
  } clcd_cmd_t;

  typedef struct packed {
    logic out_taken;
  } clcd_status_t;

  // Wake-up nibbles used during init.
  localparam logic [3:0] WakeNibble    = 4'h3;
  localparam logic [3:0] FourBitNibble = 4'h2;

  // Pin state k of a byte write: a wait, then two enable pulses.
  function automatic step_desc_t byte_step(input logic [2:0] k, input rs_sel_t rs,
                                           input byte_sel_t bsel, input hold_sel_t wsel);
    step_desc_t d;
    d.rs_sel   = rs;
    d.byte_sel = bsel;
    d.last     = 1'b0;
    case (k)
      3'd0: begin
        d.rs_sel = RS_HELD; d.enable = 1'b0; d.nib_sel = NIB_HELD; d.hold_sel = wsel;
      end
      3'd1: begin
        d.enable = 1'b1; d.nib_sel = NIB_HIGH; d.hold_sel = HOLD_STROBE;
      end
      3'd2: begin
        d.enable = 1'b0; d.nib_sel = NIB_HIGH; d.hold_sel = HOLD_ZERO;
      end
      3'd3: begin
        d.enable = 1'b1; d.nib_sel = NIB_LOW; d.hold_sel = HOLD_STROBE;
      end
      default: begin
        d.enable = 1'b0; d.nib_sel = NIB_LOW; d.hold_sel = HOLD_ZERO;
      end
    endcase
    return d;
  endfunction

  function automatic step_desc_t step_desc(input logic [2:0] op,
                                           input logic [StepWidth-1:0] idx);
    step_desc_t d;
    logic [StepWidth-1:0] k_display;
    logic [StepWidth-1:0] k_clear;
    k_display = idx - StepWidth'(9);
    k_clear   = idx - StepWidth'(14);
    d = byte_step(idx[2:0], RS_COMMAND, BYTE_VALUE, HOLD_COMMAND);
    case (op)
      OP_DATA: begin
        d = byte_step(idx[2:0], RS_DATA, BYTE_VALUE, HOLD_DATA);
        d.last = (idx == StepWidth'(4));
      end
      OP_COMMAND: begin
        d.last = (idx == StepWidth'(4));
      end
      OP_CURSOR: begin
        d = byte_step(idx[2:0], RS_COMMAND, BYTE_CURSOR, HOLD_COMMAND);
        d.last = (idx == StepWidth'(4));
      end
      OP_CLEAR: begin
        if (idx < StepWidth'(5)) begin
          d = byte_step(idx[2:0], RS_COMMAND, BYTE_CLEAR, HOLD_COMMAND);
        end else begin
          d = '{RS_HELD, 1'b0, NIB_HELD, HOLD_COMMAND, BYTE_CLEAR, 1'b1};
        end
      end
      OP_INIT: begin
        if (idx == StepWidth'(0)) begin
          d = '{RS_COMMAND, 1'b0, NIB_HELD, HOLD_POWER, BYTE_VALUE, 1'b0};
        end else if (idx < StepWidth'(7)) begin
          d = '{RS_COMMAND, idx[0], NIB_WAKE, idx[0] ? HOLD_STROBE : HOLD_INIT_STEP,
                BYTE_VALUE, 1'b0};
        end else if (idx < StepWidth'(9)) begin
          d = '{RS_COMMAND, idx[0], NIB_FOUR_BIT, idx[0] ? HOLD_STROBE : HOLD_ZERO,
                BYTE_VALUE, 1'b0};
        end else if (idx < StepWidth'(14)) begin
          d = byte_step(k_display[2:0], RS_COMMAND, BYTE_DISPLAY_ON, HOLD_COMMAND);
        end else if (idx < StepWidth'(19)) begin
          d = byte_step(k_clear[2:0], RS_COMMAND, BYTE_CLEAR, HOLD_COMMAND);
        end else begin
          d = '{RS_HELD, 1'b0, NIB_HELD, HOLD_POWER, BYTE_VALUE, 1'b1};
        end
      end
      default: begin
        d.last = 1'b1;
      end
    endcase
    return d;
  endfunction

endpackage

[design/clcd_if.sv]
// Handshake channels of the LCD write sequencer: requests, pin states and
// configuration writes. Depends on clcd_pkg for widths.
interface clcd_op_if import clcd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] value;
  logic [4:0] column;
  logic [1:0] row;
  modport source (output valid, op, value, column, row, input ready);
  modport sink (input valid, op, value, column, row, output ready);
endinterface

interface clcd_pin_if import clcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 reg_select;
  logic                 enable;
  logic [3:0]           bus_nibble;
  logic [HoldWidth-1:0] hold_us;
  logic                 last;
  modport source (output valid, reg_select, enable, bus_nibble, hold_us, last, input ready);
  modport sink (input valid, reg_select, enable, bus_nibble, hold_us, last, output ready);
endinterface

interface clcd_cfg_if import clcd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CfgIndexWidth-1:0] index;
  logic [CfgDataWidth-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/char_lcd_4bit_write_sequencer.sv]
// Character LCD write sequencer for a 4-bit HD44780-style bus. Each request
// becomes a run of pin states (register select, enable, D7..D4 and a hold
// time in microseconds), the final one marked last: five for a data, command
// or set-cursor write, six for clear and twenty for init; unused op codes are
// taken and give nothing. The controller steps one pin state at a time
// through the single output register; each pin state is held there for as
// long as the pin channel stalls. The next request is taken once the final
// pin state has been delivered. Configuration writes are taken at any time.
module char_lcd_4bit_write_sequencer import clcd_pkg::*; (
  input logic        clk,
  input logic        rst,
  clcd_op_if.sink    request,
  clcd_pin_if.source pins,
  clcd_cfg_if.sink   cfg
);

  clcd_cmd_t    cmd;
  clcd_status_t status;
  logic         req_ready;

  assign request.ready = req_ready;
  assign cfg.ready     = 1'b1;

  clcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .req_op    (request.op),
    .status    (status),
    .cmd       (cmd)
  );

  clcd_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_value       (request.value),
    .req_column      (request.column),
    .req_row         (request.row),
    .cfg_write       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .pins_valid      (pins.valid),
    .pins_ready      (pins.ready),
    .pins_reg_select (pins.reg_select),
    .pins_enable     (pins.enable),
    .pins_bus_nibble (pins.bus_nibble),
    .pins_hold_us    (pins.hold_us),
    .pins_last       (pins.last)
  );

endmodule

[design/clcd_ctrl.sv]
// Sequencing controller: takes a request and walks through its pin states.
// Depends on clcd_pkg for the step table and the command and status types.
module clcd_ctrl import clcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  logic [2:0]   req_op,
  input  clcd_status_t status,
  output clcd_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_STEP = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [2:0]           op, op_next;
  logic [StepWidth-1:0] idx, idx_next;
  step_desc_t           desc;
  logic                 accept;

  always_comb begin
    desc          = step_desc(op, idx);
    req_ready     = (state == S_IDLE);
    accept        = req_valid && req_ready;
    cmd.load_item = accept;
    cmd.load_out  = (state == S_STEP);
    cmd.desc      = desc;
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next  = req_op;
          idx_next = '0;
          // Unused op codes are taken and dropped without any pin state.
          if (req_op <= OP_CURSOR) begin
            state_next = S_STEP;
          end
        end
      end
      S_STEP: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (status.out_taken) begin
          if (desc.last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + StepWidth'(1);
            state_next = S_STEP;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_DATA;
      idx   <= '0;
    end else begin
      state <= state_next;
      op    <= op_next;
      idx   <= idx_next;
    end
  end

  // The longest operation, init, has twenty pin states.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= StepWidth'(19))
    else $error("step index beyond the longest sequence");

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept && (req_op <= OP_CURSOR) |=> (state == S_STEP) && (idx == '0))
    else $error("valid request did not start its sequence");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (req_op > OP_CURSOR) |=> (state == S_IDLE))
    else $error("unused op code started a sequence");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) && status.out_taken && desc.last |=> (state == S_IDLE))
    else $error("sequence continued after its final pin state");

endmodule

[design/clcd_datapath.sv]
// Datapath: configuration registers, held pin levels, request latch and the
// pin-state output register. Depends on clcd_pkg for the command types.
module clcd_datapath import clcd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  clcd_cmd_t                cmd,
  output clcd_status_t             status,
  input  logic [7:0]               req_value,
  input  logic [4:0]               req_column,
  input  logic [1:0]               req_row,
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output logic                     pins_valid,
  input  logic                     pins_ready,
  output logic                     pins_reg_select,
  output logic                     pins_enable,
  output logic [3:0]               pins_bus_nibble,
  output logic [HoldWidth-1:0]     pins_hold_us,
  output logic                     pins_last
);

  logic [15:0] data_wait_us;
  logic [15:0] command_wait_us;
  logic [7:0]  strobe_us;
  logic [19:0] power_wait_us;
  logic [15:0] init_step_wait_us;
  logic [7:0]  display_on_code;
  logic [7:0]  clear_code;

  logic        held_select;
  logic [3:0]  held_nibble;

  logic [7:0]  item_value;
  logic [4:0]  item_column;
  logic [1:0]  item_row;

  logic [6:0]           column_m1;
  logic [1:0]           row_m1;
  logic [7:0]           cursor_byte;
  logic [7:0]           byte_v;
  logic                 rs_v;
  logic [3:0]           nib_v;
  logic [HoldWidth-1:0] hold_v;

  always_comb begin
    // The cursor address wraps within the field widths and keeps seven bits.
    column_m1   = {2'b00, item_column} - 7'd1;
    row_m1      = item_row - 2'd1;
    cursor_byte = {1'b1, row_m1[0] | column_m1[6], column_m1[5:0]};

    case (cmd.desc.byte_sel)
      BYTE_DISPLAY_ON: byte_v = display_on_code;
      BYTE_CLEAR:      byte_v = clear_code;
      BYTE_CURSOR:     byte_v = cursor_byte;
      default:         byte_v = item_value;
    endcase

    case (cmd.desc.rs_sel)
      RS_COMMAND: rs_v = 1'b0;
      RS_DATA:    rs_v = 1'b1;
      default:    rs_v = held_select;
    endcase

    case (cmd.desc.nib_sel)
      NIB_HIGH:     nib_v = byte_v[7:4];
      NIB_LOW:      nib_v = byte_v[3:0];
      NIB_WAKE:     nib_v = WakeNibble;
      NIB_FOUR_BIT: nib_v = FourBitNibble;
      default:      nib_v = held_nibble;
    endcase

    case (cmd.desc.hold_sel)
      HOLD_STROBE:    hold_v = HoldWidth'(strobe_us);
      HOLD_DATA:      hold_v = HoldWidth'(data_wait_us);
      HOLD_COMMAND:   hold_v = HoldWidth'(command_wait_us);
      HOLD_POWER:     hold_v = power_wait_us;
      HOLD_INIT_STEP: hold_v = HoldWidth'(init_step_wait_us);
      default:        hold_v = '0;
    endcase

    status.out_taken = pins_valid && pins_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_wait_us      <= DataWaitReset;
      command_wait_us   <= CommandWaitReset;
      strobe_us         <= StrobeReset;
      power_wait_us     <= PowerWaitReset;
      init_step_wait_us <= InitStepReset;
      display_on_code   <= DisplayOnReset;
      clear_code        <= ClearCodeReset;
      held_select       <= 1'b0;
      held_nibble       <= '0;
      pins_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DATA_WAIT:    data_wait_us      <= cfg_data[15:0];
          REG_COMMAND_WAIT: command_wait_us   <= cfg_data[15:0];
          REG_STROBE:       strobe_us         <= cfg_data[7:0];
          REG_POWER_WAIT:   power_wait_us     <= cfg_data;
          REG_INIT_STEP:    init_step_wait_us <= cfg_data[15:0];
          REG_DISPLAY_ON:   display_on_code   <= cfg_data[7:0];
          REG_CLEAR_CODE:   clear_code        <= cfg_data[7:0];
          default: ;
        endcase
      end
      // Every pin state leaves its levels behind for the next one.
      if (cmd.load_out) begin
        pins_valid  <= 1'b1;
        held_select <= rs_v;
        held_nibble <= nib_v;
      end else if (status.out_taken) begin
        pins_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_value  <= req_value;
      item_column <= req_column;
      item_row    <= req_row;
    end
    if (cmd.load_out) begin
      pins_reg_select <= rs_v;
      pins_enable     <= cmd.desc.enable;
      pins_bus_nibble <= nib_v;
      pins_hold_us    <= hold_v;
      pins_last       <= cmd.desc.last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !pins_valid)
    else $error("pin state loaded over one not yet taken");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |-> !pins_valid)
    else $error("request latched while a pin state is pending");

  a_held_follows: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) |-> (held_nibble == pins_bus_nibble)
                            && (held_select == pins_reg_select))
    else $error("held pin levels differ from the last pin state");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the character LCD write sequencer: drives
// requests and register writes, predicts every pin state and checks each one.
// Depends on clcd_pkg and the channel interfaces of clcd_if.sv.
module tb_top;
  import clcd_pkg::*;

  localparam int CycleLimit   = 500000;
  localparam int SettleCycles = 40;
  localparam int RandomItems  = 200;
  localparam int RandomPhases = 4;
  localparam int MaxIdle      = 11;

  // Op codes that the block takes and ignores.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                 rs;
    logic                 en;
    logic [3:0]           nibble;
    logic [HoldWidth-1:0] hold;
    logic                 last;
  } pin_state_t;

  logic clk;
  logic rst;

  clcd_op_if  req_ch();
  clcd_pin_if pin_ch();
  clcd_cfg_if cfg_ch();

  char_lcd_4bit_write_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .pins    (pin_ch),
    .cfg     (cfg_ch)
  );

  // Predicted register file and pin levels left by the previous op.
  logic [15:0] data_wait;
  logic [15:0] command_wait;
  logic [7:0]  strobe_width;
  logic [19:0] power_wait;
  logic [15:0] init_step_wait;
  logic [7:0]  display_on_byte;
  logic [7:0]  clear_byte;
  logic [3:0]  held_nibble;
  logic        held_select;

  pin_state_t              pending_pins[$];
  logic [CfgDataWidth-1:0] reg_plan[8];
  bit                      failed = 1'b0;
  bit                      idle_on = 1'b1;
  int                      pin_stall = 0;
  int unsigned             cycle_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void reset_model();
    data_wait       = DataWaitReset;
    command_wait    = CommandWaitReset;
    strobe_width    = StrobeReset;
    power_wait      = PowerWaitReset;
    init_step_wait  = InitStepReset;
    display_on_byte = DisplayOnReset;
    clear_byte      = ClearCodeReset;
    held_nibble     = 4'h0;
    held_select     = 1'b0;
  endfunction

  function automatic void apply_register(input logic [CfgIndexWidth-1:0] index,
                                         input logic [CfgDataWidth-1:0] data);
    case (index)
      REG_DATA_WAIT:    data_wait = data[15:0];
      REG_COMMAND_WAIT: command_wait = data[15:0];
      REG_STROBE:       strobe_width = data[7:0];
      REG_POWER_WAIT:   power_wait = data[19:0];
      REG_INIT_STEP:    init_step_wait = data[15:0];
      REG_DISPLAY_ON:   display_on_byte = data[7:0];
      REG_CLEAR_CODE:   clear_byte = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic void push_pin(input logic rs, input logic en, input logic [3:0] nibble,
                                   input logic [HoldWidth-1:0] hold);
    pin_state_t p;
    p.rs     = rs;
    p.en     = en;
    p.nibble = nibble;
    p.hold   = hold;
    p.last   = 1'b0;
    pending_pins.push_back(p);
  endfunction

  // An enable pulse of the strobe width, then enable low for low_hold.
  function automatic void pulse_nibble(input logic [3:0] nibble,
                                       input logic [HoldWidth-1:0] low_hold);
    held_nibble = nibble;
    push_pin(held_select, 1'b1, held_nibble, HoldWidth'(strobe_width));
    push_pin(held_select, 1'b0, held_nibble, low_hold);
  endfunction

  // The wait is held on the old pins; the new select only shows with the pulses.
  function automatic void write_byte(input logic rs, input logic [7:0] byte_val,
                                     input logic [HoldWidth-1:0] wait_us);
    push_pin(held_select, 1'b0, held_nibble, wait_us);
    held_select = rs;
    pulse_nibble(byte_val[7:4], '0);
    pulse_nibble(byte_val[3:0], '0);
  endfunction

  function automatic void predict_lcd_op(input logic [2:0] op, input logic [7:0] value,
                                         input logic [4:0] column, input logic [1:0] row);
    int         start;
    logic [7:0] col_less;
    logic [1:0] row_less;
    logic [7:0] address;
    pin_state_t tail;
    start = pending_pins.size();
    case (op)
      OP_DATA:    write_byte(1'b1, value, HoldWidth'(data_wait));
      OP_COMMAND: write_byte(1'b0, value, HoldWidth'(command_wait));
      OP_INIT: begin
        held_select = 1'b0;
        push_pin(1'b0, 1'b0, held_nibble, power_wait);
        pulse_nibble(WakeNibble, HoldWidth'(init_step_wait));
        pulse_nibble(WakeNibble, HoldWidth'(init_step_wait));
        pulse_nibble(WakeNibble, HoldWidth'(init_step_wait));
        pulse_nibble(FourBitNibble, '0);
        write_byte(1'b0, display_on_byte, HoldWidth'(command_wait));
        write_byte(1'b0, clear_byte, HoldWidth'(command_wait));
        push_pin(held_select, 1'b0, held_nibble, power_wait);
      end
      OP_CLEAR: begin
        write_byte(1'b0, clear_byte, HoldWidth'(command_wait));
        push_pin(held_select, 1'b0, held_nibble, HoldWidth'(command_wait));
      end
      OP_CURSOR: begin
        // The column is widened before the subtraction so that column 0 wraps to 0x7F.
        col_less = {3'b000, column} - 8'd1;
        row_less = row - 2'd1;
        address  = ({row_less, 6'b000000} | col_less) & 8'h7F;
        write_byte(1'b0, 8'h80 | address, HoldWidth'(command_wait));
      end
      default: ;
    endcase
    if (pending_pins.size() > start) begin
      tail = pending_pins.pop_back();
      tail.last = 1'b1;
      pending_pins.push_back(tail);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [HoldWidth-1:0] want,
                                        input logic [HoldWidth-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic void check_pin_state();
    pin_state_t want;
    if (pending_pins.size() == 0) begin
      $error("pin state with nothing expected: rs=%0b en=%0b nibble=%0h hold=%0d last=%0b",
             pin_ch.reg_select, pin_ch.enable, pin_ch.bus_nibble, pin_ch.hold_us, pin_ch.last);
      failed = 1'b1;
    end else begin
      want = pending_pins.pop_front();
      compare_field("reg_select", HoldWidth'(want.rs), HoldWidth'(pin_ch.reg_select));
      compare_field("enable", HoldWidth'(want.en), HoldWidth'(pin_ch.enable));
      compare_field("bus_nibble", HoldWidth'(want.nibble), HoldWidth'(pin_ch.bus_nibble));
      compare_field("hold_us", want.hold, pin_ch.hold_us);
      compare_field("last", HoldWidth'(want.last), HoldWidth'(pin_ch.last));
    end
  endfunction

  // Pin channel sink: each transaction is checked, then, while idling is on,
  // ready may drop for a randomly drawn stall.
  always @(posedge clk) begin
    if (rst) begin
      pin_ch.ready <= 1'b0;
      pin_stall = 0;
    end else begin
      if (pin_ch.valid && pin_ch.ready) begin
        check_pin_state();
        pin_stall = idle_on ? $urandom_range(0, MaxIdle) : 0;
      end else if (pin_stall > 0) begin
        pin_stall = pin_stall - 1;
      end
      pin_ch.ready <= (pin_stall == 0);
    end
  end

  // Valid is left high after a transaction so that the next one can follow
  // at once; whoever stops sending lowers it.
  task automatic send_op(input logic [2:0] op, input logic [7:0] value,
                         input logic [4:0] column, input logic [1:0] row);
    int gap;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.op     <= op;
    req_ch.value  <= value;
    req_ch.column <= column;
    req_ch.row    <= row;
    do @(posedge clk); while (!req_ch.ready);
    predict_lcd_op(op, value, column, row);
  endtask

  // Ignored ops give no pin state, so a quiet queue does not prove the block
  // idle; the settle time covers one still in flight.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes reg_plan to every index, the unused one included.
  task automatic load_registers();
    for (int i = 0; i < 8; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CfgIndexWidth'(i);
      cfg_ch.data  <= reg_plan[i];
      do @(posedge clk); while (!cfg_ch.ready);
      apply_register(CfgIndexWidth'(i), reg_plan[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_op(OP_DATA, 8'h41, 5'd1, 2'd1);
    send_op(OP_COMMAND, 8'h28, 5'd1, 2'd1);
    send_op(OP_CURSOR, 8'h00, 5'd1, 2'd1);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    send_op(OP_INIT, 8'hFF, 5'd31, 2'd3);
    send_op(OP_DATA, 8'h00, 5'd0, 2'd0);
    send_op(OP_DATA, 8'hFF, 5'd31, 2'd3);
    send_op(OP_COMMAND, 8'h00, 5'd16, 2'd2);
    send_op(OP_COMMAND, 8'hFF, 5'd1, 2'd1);
    send_op(OP_CURSOR, 8'hFF, 5'd16, 2'd2);
    send_op(OP_CURSOR, 8'h00, 5'd16, 2'd1);
    send_op(OP_CURSOR, 8'h00, 5'd1, 2'd2);
    // Row and column outside the display wrap within the address.
    send_op(OP_CURSOR, 8'h00, 5'd0, 2'd0);
    send_op(OP_CURSOR, 8'h00, 5'd31, 2'd3);
    send_op(OP_CURSOR, 8'h00, 5'd17, 2'd1);
    send_op(OP_SPARE_5, 8'hFF, 5'd31, 2'd3);
    send_op(OP_SPARE_6, 8'h00, 5'd0, 2'd0);
    send_op(OP_SPARE_7, 8'hA5, 5'd10, 2'd2);
    send_op(OP_DATA, 8'h5A, 5'd1, 2'd1);
    send_op(OP_CLEAR, 8'h00, 5'd1, 2'd1);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // All ones: every register saturates and the narrower ones drop the upper data bits.
    for (int i = 0; i < 8; i++) reg_plan[i] = 20'hFFFFF;
    load_registers();
    send_op(OP_INIT, 8'h00, 5'd1, 2'd1);
    send_op(OP_DATA, 8'hA5, 5'd1, 2'd1);
    send_op(OP_CLEAR, 8'h00, 5'd1, 2'd1);
    send_op(OP_CURSOR, 8'h00, 5'd5, 2'd2);
    wait_idle();
    // All zeros, which gives enable pulses of no width.
    for (int i = 0; i < 8; i++) reg_plan[i] = '0;
    load_registers();
    send_op(OP_INIT, 8'h00, 5'd1, 2'd1);
    send_op(OP_COMMAND, 8'h5A, 5'd1, 2'd1);
    send_op(OP_CLEAR, 8'h00, 5'd1, 2'd1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int         pick;
    int         sent;
    logic [2:0] op;
    logic [4:0] column;
    logic [1:0] row;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      // The first phase runs with no idling on either side.
      idle_on = (phase != 0);
      for (int i = 0; i < 8; i++) reg_plan[i] = CfgDataWidth'($urandom_range(0, 20'hFFFFF));
      if (phase == 1) reg_plan[REG_STROBE] = '0;
      load_registers();
      sent = 0;
      while (sent < RandomItems / RandomPhases) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
        else if (pick < 40) op = OP_DATA;
        else if (pick < 58) op = OP_COMMAND;
        else if (pick < 78) op = OP_CURSOR;
        else if (pick < 89) op = OP_CLEAR;
        else op = OP_INIT;
        column = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 16));
        row = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                          : 2'($urandom_range(1, 2));
        send_op(op, 8'($urandom_range(0, 255)), column, row);
        if (op <= OP_CURSOR) sent++;
      end
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.op     <= OP_DATA;
    req_ch.value  <= 8'h00;
    req_ch.column <= 5'd1;
    req_ch.row    <= 2'd1;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_DATA_WAIT;
    cfg_ch.data   <= '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_field_extremes();
    test_register_extremes();
    test_random_traffic();

    if (pending_pins.size() != 0) begin
      $error("%0d expected pin states never arrived", pending_pins.size());
    end
    if (!failed && (pending_pins.size() == 0)) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
